>>> rtl/core/fbw_pkg.sv
// ----------------------------------------------------------------------------
// fbw_pkg: shared types and constants of the windowed frame-buffer writer
// Holds the channel word layouts, operation and status codes, register
// indexes and the command word that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package fbw_pkg;

  // Operation codes of an input word.
  localparam logic [2:0] OP_SET_WINDOW  = 3'd0;
  localparam logic [2:0] OP_WRITE_PIXEL = 3'd1;
  localparam logic [2:0] OP_DRAW_PIXEL  = 3'd2;
  localparam logic [2:0] OP_CLEAR       = 3'd3;
  localparam logic [2:0] OP_READ_BYTE   = 3'd4;

  // Pixel formats.
  localparam logic [1:0] MODE_1BIT  = 2'd0;
  localparam logic [1:0] MODE_8BIT  = 2'd1;
  localparam logic [1:0] MODE_16BIT = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OFFSCREEN = 2'd1;
  localparam logic [1:0] ST_BEYOND    = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_DEPTH_MODE = 2'd0;
  localparam logic [1:0] CFG_X_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_Y_LIMIT    = 2'd2;

  localparam logic [1:0] DEPTH_MODE_RST = MODE_16BIT;
  localparam logic [7:0] X_LIMIT_RST    = 8'd95;
  localparam logic [7:0] Y_LIMIT_RST    = 8'd63;

  // Command kinds carried through the queue.
  localparam logic [2:0] CMD_STATUS = 3'd0;
  localparam logic [2:0] CMD_WR8    = 3'd1;
  localparam logic [2:0] CMD_WR16   = 3'd2;
  localparam logic [2:0] CMD_BIT    = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  // Byte addresses in commands are wide enough for the largest buffer.
  localparam int PTR_W = 16;

  // Command queue depth; a power of two so that the pointers wrap freely.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [7:0]  col_end;
    logic [7:0]  row_end;
    logic [15:0] pixel_color;
    logic [13:0] byte_address;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic [1:0] index;
    logic [7:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic [1:0] depth_mode;
    logic [7:0] x_limit;
    logic [7:0] y_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [PTR_W-1:0] addr;
    logic [15:0]      data;
    logic [2:0]       bit_sel;
    logic [1:0]       status;
  } cmd_t;

endpackage

>>> rtl/core/fbw_chan_if.sv
// ----------------------------------------------------------------------------
// fbw_chan_if: valid/ready channel
// Carries one word of the given type from a source to a sink.
// ----------------------------------------------------------------------------
interface fbw_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/fbw_ram.sv
// ----------------------------------------------------------------------------
// fbw_ram: single-port synchronous RAM
// One access a cycle while en is high: we high writes, else a registered read.
// ----------------------------------------------------------------------------
module fbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> rtl/core/fbw_front.sv
// ----------------------------------------------------------------------------
// fbw_front: word intake, window and cursor
// Takes an input word, updates the drawing window, works out the byte
// address of a pixel from the cursor and hands a command to the queue.
// ----------------------------------------------------------------------------
module fbw_front
  import fbw_pkg::*;
#(
  parameter int BUFFER_BYTES = 16384
) (
  input  logic       clk,
  input  logic       rst_n,
  fbw_chan_if.sink   in_chan,
  input  cfg_regs_t  cfg,
  input  logic       init_done,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam logic       F_IDLE = 1'b0;
  localparam logic       F_WORK = 1'b1;
  localparam logic [17:0] BUF_LIM = 18'(BUFFER_BYTES);

  logic state_r, state_nxt;
  logic accept;

  logic [2:0]  op_r;
  logic [15:0] color_r;
  logic [13:0] addr_r;
  logic        offscreen_r;

  logic [7:0] cur_col_r, cur_col_nxt;
  logic [7:0] cur_row_r, cur_row_nxt;
  logic [7:0] win_col_start_r, win_col_start_nxt;
  logic [7:0] win_col_end_r, win_col_end_nxt;
  logic [7:0] win_row_start_r, win_row_start_nxt;
  logic [7:0] win_row_end_r, win_row_end_nxt;

  logic       on_screen;
  logic       load_win;
  logic [7:0] start_col, start_row, end_col, end_row;

  logic [7:0]  row_sel;
  logic [8:0]  width9;
  logic [16:0] prod;
  logic [16:0] offset;
  logic [17:0] last_byte;
  logic        in_range;
  logic        is_pixel;
  logic        col_wrap, row_wrap;

  assign in_chan.ready = (state_r == F_IDLE) && init_done;
  assign accept        = in_chan.valid && in_chan.ready;

  // Window load for set window, and for draw pixel when the point is on screen.
  always_comb begin
    on_screen = (in_chan.data.pixel_x <= cfg.x_limit) &&
                (in_chan.data.pixel_y <= cfg.y_limit);
    start_col = (in_chan.data.pixel_x > cfg.x_limit) ? cfg.x_limit : in_chan.data.pixel_x;
    start_row = (in_chan.data.pixel_y > cfg.y_limit) ? cfg.y_limit : in_chan.data.pixel_y;
    if (in_chan.data.operation == OP_DRAW_PIXEL) begin
      end_col = cfg.x_limit;
      end_row = cfg.y_limit;
    end else begin
      end_col = (in_chan.data.col_end > cfg.x_limit) ? cfg.x_limit : in_chan.data.col_end;
      end_row = (in_chan.data.row_end > cfg.y_limit) ? cfg.y_limit : in_chan.data.row_end;
    end
    load_win = accept && ((in_chan.data.operation == OP_SET_WINDOW) ||
                          ((in_chan.data.operation == OP_DRAW_PIXEL) && on_screen));
  end

  // Pixel placement: one multiplier serves all three formats.
  always_comb begin
    row_sel   = (cfg.depth_mode == MODE_1BIT) ? {3'b000, cur_row_r[7:3]} : cur_row_r;
    width9    = {1'b0, cfg.x_limit} + 9'd1;
    prod      = {9'b0, row_sel} * {8'b0, width9};
    offset    = prod + {9'b0, cur_col_r};
    last_byte = (cfg.depth_mode == MODE_16BIT) ? ({offset, 1'b0} + 18'd1) : {1'b0, offset};
    in_range  = last_byte < BUF_LIM;
  end

  assign is_pixel = (op_r == OP_WRITE_PIXEL) || ((op_r == OP_DRAW_PIXEL) && !offscreen_r);
  assign q_push   = (state_r == F_WORK) && !q_full;

  always_comb begin
    q_cmd         = '0;
    q_cmd.kind    = CMD_STATUS;
    q_cmd.data    = color_r;
    q_cmd.bit_sel = cur_row_r[2:0];
    q_cmd.status  = ST_DONE;
    case (op_r)
      OP_WRITE_PIXEL, OP_DRAW_PIXEL: begin
        if (!is_pixel) begin
          q_cmd.status = ST_OFFSCREEN;
        end else if ((cfg.depth_mode == MODE_16BIT) || (cfg.depth_mode == MODE_8BIT) ||
                     (cfg.depth_mode == MODE_1BIT)) begin
          if (!in_range) begin
            q_cmd.status = ST_BEYOND;
          end else if (cfg.depth_mode == MODE_16BIT) begin
            q_cmd.kind = CMD_WR16;
            q_cmd.addr = {offset[PTR_W-2:0], 1'b0};
          end else if (cfg.depth_mode == MODE_8BIT) begin
            q_cmd.kind = CMD_WR8;
            q_cmd.addr = offset[PTR_W-1:0];
          end else begin
            q_cmd.kind = CMD_BIT;
            q_cmd.addr = offset[PTR_W-1:0];
          end
        end
      end
      OP_CLEAR: begin
        q_cmd.kind = CMD_CLEAR;
      end
      OP_READ_BYTE: begin
        if ({4'b0, addr_r} < BUF_LIM) begin
          q_cmd.kind = CMD_READ;
          q_cmd.addr = {2'b00, addr_r};
        end else begin
          q_cmd.status = ST_BEYOND;
        end
      end
      default: begin
        q_cmd.kind = CMD_STATUS;
      end
    endcase
  end

  // Window load, next state, and cursor advance after every pixel, whether or not it was stored.
  always_comb begin
    col_wrap = ({1'b0, cur_col_r} + 9'd1) > {1'b0, win_col_end_r};
    row_wrap = ({1'b0, cur_row_r} + 9'd1) >= {1'b0, win_row_end_r};

    cur_col_nxt       = cur_col_r;
    cur_row_nxt       = cur_row_r;
    win_col_start_nxt = win_col_start_r;
    win_col_end_nxt   = win_col_end_r;
    win_row_start_nxt = win_row_start_r;
    win_row_end_nxt   = win_row_end_r;
    state_nxt         = state_r;

    if (load_win) begin
      cur_col_nxt       = start_col;
      cur_row_nxt       = start_row;
      win_col_start_nxt = start_col;
      win_col_end_nxt   = end_col;
      win_row_start_nxt = start_row;
      win_row_end_nxt   = end_row;
    end else if (q_push && is_pixel) begin
      if (col_wrap) begin
        cur_col_nxt = win_col_start_r;
        cur_row_nxt = row_wrap ? win_row_start_r : (cur_row_r + 8'd1);
      end else begin
        cur_col_nxt = cur_col_r + 8'd1;
      end
    end

    case (state_r)
      F_IDLE:  if (accept) state_nxt = F_WORK;
      F_WORK:  if (q_push) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= F_IDLE;
      cur_col_r       <= '0;
      cur_row_r       <= '0;
      win_col_start_r <= '0;
      win_col_end_r   <= '0;
      win_row_start_r <= '0;
      win_row_end_r   <= '0;
    end else begin
      state_r         <= state_nxt;
      cur_col_r       <= cur_col_nxt;
      cur_row_r       <= cur_row_nxt;
      win_col_start_r <= win_col_start_nxt;
      win_col_end_r   <= win_col_end_nxt;
      win_row_start_r <= win_row_start_nxt;
      win_row_end_r   <= win_row_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= in_chan.data.operation;
      color_r     <= in_chan.data.pixel_color;
      addr_r      <= in_chan.data.byte_address;
      offscreen_r <= !on_screen;
    end
  end

`ifndef SYNTH
  a_window_loads_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_chan.data.operation == OP_SET_WINDOW)) |=>
      (cur_col_r == win_col_start_r && cur_row_r == win_row_start_r))
    else $error("set window did not place the cursor at the window start");
`endif

endmodule

>>> rtl/core/fbw_cmd_fifo.sv
// ----------------------------------------------------------------------------
// fbw_cmd_fifo: command queue
// Short queue of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module fbw_cmd_fifo
  import fbw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? (wr_ptr_r + PTR_BITS'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop ? (rd_ptr_r + PTR_BITS'(1)) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("command pushed into a full queue");
`endif

endmodule

>>> rtl/core/fbw_back.sv
// ----------------------------------------------------------------------------
// fbw_back: frame store sequencer
// Carries out queued commands on the frame store RAM, sweeps it clear after
// reset and on a clear command, and holds the result word for the receiver.
// ----------------------------------------------------------------------------
module fbw_back
  import fbw_pkg::*;
#(
  parameter int BUFFER_BYTES = 16384
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  fbw_chan_if.source out_chan,
  output logic       init_done
);

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUFFER_BYTES - 1);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_WR_LO = 3'd1;
  localparam logic [2:0] B_RMW   = 3'd2;
  localparam logic [2:0] B_RD    = 3'd3;
  localparam logic [2:0] B_SWEEP = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              init_done_r, init_done_nxt;
  logic [ADDR_W-1:0] lat_addr_r, lat_addr_nxt;
  logic [7:0]        lat_byte_r, lat_byte_nxt;
  logic [2:0]        lat_bit_r, lat_bit_nxt;
  logic              lat_set_r, lat_set_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r;

  logic              slot_free;
  logic              emit;
  out_word_t         emit_word;
  logic [ADDR_W-1:0] head_addr;
  logic [7:0]        bit_mask;

  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;

  fbw_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign slot_free      = !out_valid_r || out_chan.ready;
  assign q_pop          = (state_r == B_IDLE) && !q_empty && slot_free;
  assign head_addr      = q_head.addr[ADDR_W-1:0];
  assign bit_mask       = 8'd1 << lat_bit_r;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_word_r;
  assign init_done      = init_done_r;

  always_comb begin
    state_nxt           = state_r;
    clr_cnt_nxt         = clr_cnt_r;
    init_done_nxt       = init_done_r;
    lat_addr_nxt        = lat_addr_r;
    lat_byte_nxt        = lat_byte_r;
    lat_bit_nxt         = lat_bit_r;
    lat_set_nxt         = lat_set_r;
    ram_en              = 1'b0;
    ram_we              = 1'b0;
    ram_addr            = lat_addr_r;
    ram_wdata           = 8'h00;
    emit                = 1'b0;
    emit_word.read_data = 8'h00;
    emit_word.status    = q_head.status;

    case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          case (q_head.kind)
            CMD_WR8: begin
              ram_en    = 1'b1;
              ram_we    = 1'b1;
              ram_addr  = head_addr;
              ram_wdata = q_head.data[7:0];
              emit      = 1'b1;
            end
            CMD_WR16: begin
              ram_en       = 1'b1;
              ram_we       = 1'b1;
              ram_addr     = head_addr;
              ram_wdata    = q_head.data[15:8];
              lat_addr_nxt = head_addr + ADDR_W'(1);
              lat_byte_nxt = q_head.data[7:0];
              state_nxt    = B_WR_LO;
              emit         = 1'b1;
            end
            CMD_BIT: begin
              ram_en       = 1'b1;
              ram_addr     = head_addr;
              lat_addr_nxt = head_addr;
              lat_bit_nxt  = q_head.bit_sel;
              lat_set_nxt  = |q_head.data;
              state_nxt    = B_RMW;
              emit         = 1'b1;
            end
            CMD_READ: begin
              ram_en    = 1'b1;
              ram_addr  = head_addr;
              state_nxt = B_RD;
            end
            CMD_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = B_SWEEP;
              emit        = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      B_WR_LO: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = lat_byte_r;
        state_nxt = B_IDLE;
      end
      B_RMW: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = lat_set_r ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        state_nxt = B_IDLE;
      end
      B_RD: begin
        emit                = 1'b1;
        emit_word.read_data = ram_rdata;
        emit_word.status    = ST_DONE;
        state_nxt           = B_IDLE;
      end
      B_SWEEP: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_cnt_r;
        if (clr_cnt_r == LAST_ADDR) begin
          init_done_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_SWEEP;
      clr_cnt_r   <= '0;
      init_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      init_done_r <= init_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lat_addr_r <= lat_addr_nxt;
    lat_byte_r <= lat_byte_nxt;
    lat_bit_r  <= lat_bit_nxt;
    lat_set_r  <= lat_set_nxt;
    if (emit) begin
      out_word_r <= emit_word;
    end
  end

`ifndef SYNTH
  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free)
    else $error("result loaded over a word the receiver has not taken");

  a_read_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RD) |-> !out_valid_r)
    else $error("read data returned while the result register is occupied");

  a_init_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(init_done_r) |-> (state_r == B_IDLE && $past(clr_cnt_r) == LAST_ADDR))
    else $error("store marked ready before the clearing sweep finished");
`endif

endmodule

>>> rtl/core/windowed_frame_buffer_writer.sv
// ----------------------------------------------------------------------------
// windowed_frame_buffer_writer: frame store with drawing window and cursor
// Top level: configuration registers, front end, command queue and back end.
// ----------------------------------------------------------------------------
// Usage. Words arrive on in_chan: set window, write pixel, draw pixel, clear
// or read byte. Every accepted word gives exactly one result word on
// out_chan, in order, holding the byte read (zero for other operations) and
// a status. Configuration (pixel format and screen limits) is written on
// cfg_chan, which is always ready, and should only change while no word is
// in flight.
// After reset the store is swept to zero, one byte a cycle; in_chan stays
// not ready until the sweep is over. The front end accepts a word and loads
// the window, then works out the pixel address and queues a command, waiting
// while the queue is full; it takes no new word until then. The back end
// owns the single RAM port and pops no new command until the last is done:
// status-only and eight-bit writes are done as popped, sixteen-bit writes
// store the high byte, then the low byte, one-bit writes read, then modify
// and write, reads read, then return the byte, and clears sweep the store.
// When the receiver stalls, the result register holds its word, the back end
// stops taking commands, the queue fills and in_chan then stops accepting.
// ----------------------------------------------------------------------------
module windowed_frame_buffer_writer
  import fbw_pkg::*;
#(
  parameter int BUFFER_BYTES = 16384
) (
  input  logic       clk,
  input  logic       rst_n,
  fbw_chan_if.sink   in_chan,
  fbw_chan_if.source out_chan,
  fbw_chan_if.sink   cfg_chan
);

  // Configuration registers, written by index.
  cfg_regs_t cfg_r, cfg_nxt;

  // Front end to queue, and queue to back end.
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  logic q_pop;
  cmd_t q_head;
  logic q_empty;

  // The front end waits for the start-up sweep of the store.
  logic init_done;

  assign cfg_chan.ready = 1'b1;

  // A write to an index past the last register is dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.data.index)
        CFG_DEPTH_MODE: cfg_nxt.depth_mode = cfg_chan.data.value[1:0];
        CFG_X_LIMIT:    cfg_nxt.x_limit    = cfg_chan.data.value;
        CFG_Y_LIMIT:    cfg_nxt.y_limit    = cfg_chan.data.value;
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_mode <= DEPTH_MODE_RST;
      cfg_r.x_limit    <= X_LIMIT_RST;
      cfg_r.y_limit    <= Y_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: intake, window and cursor, pixel address.
  fbw_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg       (cfg_r),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_push_cmd)
  );

  // Short queue so that each side can stall on its own.
  fbw_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Back end: RAM sequencing, clearing sweeps and the result register.
  fbw_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_chan  (out_chan),
    .init_done (init_done)
  );

endmodule

>>> verif/tb_windowed_frame_buffer_writer.sv
// ----------------------------------------------------------------------------
// tb_windowed_frame_buffer_writer: self-checking bench for the frame writer
// Drives set-window, pixel, draw, clear and read words through the block
// under changing pixel formats and screen limits. A scoreboard keeps its own
// copy of the frame store, cursor and window, works out every reply as the
// word is accepted and compares the block's replies with it in order.
// ----------------------------------------------------------------------------
module tb_windowed_frame_buffer_writer;
  import fbw_pkg::*;

  localparam int BUFFER_BYTES = 16384;

  // A clear or the sweep after reset keeps every channel quiet while every
  // byte of the store is swept; the limit allows several times as long.
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 16;

  localparam int RANDOM_PHASES     = 10;
  localparam int PHASE_WORDS       = 145;
  localparam int MAX_RANDOM_CLEARS = 6;

  // Codes outside the package lists: reserved operations, the unused pixel
  // format and a register index beyond the register list.
  localparam logic [2:0] OP_FIRST_RESERVED = 3'd5;
  localparam logic [2:0] OP_LAST_RESERVED  = 3'd7;
  localparam logic [1:0] MODE_UNUSED       = 2'd3;
  localparam logic [1:0] CFG_UNUSED        = 2'd3;

  // --------------------------------------------------------------------------
  // Scoreboard: a private copy of the block's state, the replies that are
  // still owed, and the comparison against what actually comes out.
  // --------------------------------------------------------------------------
  class reply_scoreboard;
    logic [7:0] frame_bytes [BUFFER_BYTES];
    logic [1:0] depth_mode;
    logic [7:0] x_limit, y_limit;
    logic [7:0] cur_col, cur_row;
    logic [7:0] win_col_start, win_col_end, win_row_start, win_row_end;
    out_word_t  replies_due [$];
    int         errors;

    function new();
      wipe();
      depth_mode    = DEPTH_MODE_RST;
      x_limit       = X_LIMIT_RST;
      y_limit       = Y_LIMIT_RST;
      cur_col       = '0;
      cur_row       = '0;
      win_col_start = '0;
      win_col_end   = '0;
      win_row_start = '0;
      win_row_end   = '0;
      errors        = 0;
    endfunction

    function void wipe();
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    endfunction

    // Only the low two bits of a format write count; unknown indexes are dropped.
    function void write_register(cfg_word_t w);
      case (w.index)
        CFG_DEPTH_MODE: depth_mode = w.value[1:0];
        CFG_X_LIMIT:    x_limit    = w.value;
        CFG_Y_LIMIT:    y_limit    = w.value;
        default: ;
      endcase
    endfunction

    function logic [7:0] clamp(logic [7:0] v, logic [7:0] lim);
      return (v > lim) ? lim : v;
    endfunction

    function void load_window(logic [7:0] x, logic [7:0] xe, logic [7:0] y,
                              logic [7:0] ye);
      cur_col       = clamp(x, x_limit);
      win_col_start = cur_col;
      win_col_end   = clamp(xe, x_limit);
      cur_row       = clamp(y, y_limit);
      win_row_start = cur_row;
      win_row_end   = clamp(ye, y_limit);
    endfunction

    // Stores one pixel at the cursor and moves the cursor on. The address is
    // worked out with the current width, whatever the window was set under.
    function logic [1:0] put_pixel(logic [15:0] colour);
      int         width, offset, pos;
      logic [7:0] mask;
      logic [1:0] st;
      width  = int'(x_limit) + 1;
      offset = int'(cur_row) * width + int'(cur_col);
      st     = ST_DONE;
      case (depth_mode)
        MODE_16BIT: begin
          if (2 * offset + 1 < BUFFER_BYTES) begin
            frame_bytes[2 * offset]     = colour[15:8];
            frame_bytes[2 * offset + 1] = colour[7:0];
          end else begin
            st = ST_BEYOND;
          end
        end
        MODE_8BIT: begin
          if (offset < BUFFER_BYTES) frame_bytes[offset] = colour[7:0];
          else st = ST_BEYOND;
        end
        MODE_1BIT: begin
          pos  = int'(cur_col) + (int'(cur_row) / 8) * width;
          mask = 8'h01 << cur_row[2:0];
          if (pos >= BUFFER_BYTES) st = ST_BEYOND;
          else if (colour != 16'h0000) frame_bytes[pos] = frame_bytes[pos] | mask;
          else frame_bytes[pos] = frame_bytes[pos] & ~mask;
        end
        default: ;
      endcase
      // The row end is exclusive when the row steps; the sums are not
      // limited to eight bits, so a cursor at 255 always wraps.
      if (int'(cur_col) + 1 > int'(win_col_end)) begin
        cur_col = win_col_start;
        if (int'(cur_row) + 1 >= int'(win_row_end)) cur_row = win_row_start;
        else cur_row = cur_row + 8'd1;
      end else begin
        cur_col = cur_col + 8'd1;
      end
      return st;
    endfunction

    function void predict_reply(in_word_t w);
      out_word_t reply;
      reply.read_data = 8'h00;
      reply.status    = ST_DONE;
      case (w.operation)
        OP_SET_WINDOW:  load_window(w.pixel_x, w.col_end, w.pixel_y, w.row_end);
        OP_WRITE_PIXEL: reply.status = put_pixel(w.pixel_color);
        OP_DRAW_PIXEL: begin
          if (w.pixel_x > x_limit || w.pixel_y > y_limit) begin
            reply.status = ST_OFFSCREEN;
          end else begin
            load_window(w.pixel_x, x_limit, w.pixel_y, y_limit);
            reply.status = put_pixel(w.pixel_color);
          end
        end
        OP_CLEAR: wipe();
        OP_READ_BYTE: begin
          if (int'(w.byte_address) < BUFFER_BYTES) begin
            reply.read_data = frame_bytes[w.byte_address];
          end else begin
            reply.status = ST_BEYOND;
          end
        end
        default: ;
      endcase
      replies_due.push_back(reply);
    endfunction

    function void check_reply(out_word_t got);
      out_word_t want;
      if (replies_due.size() == 0) begin
        $error("reply with nothing outstanding: read_data %0d, status %0d",
               got.read_data, got.status);
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (got.read_data !== want.read_data) begin
          $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block itself.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always #10 clk = ~clk;

  fbw_chan_if #(.T(in_word_t))  in_if ();
  fbw_chan_if #(.T(out_word_t)) out_if ();
  fbw_chan_if #(.T(cfg_word_t)) cfg_if ();

  windowed_frame_buffer_writer #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  reply_scoreboard sb = new();

  int burst_left     = 0;
  bit hold_off_armed = 1'b0;
  int idle_cycles    = 0;

  // --------------------------------------------------------------------------
  // Monitor and watchdog. Handshakes are sampled at the rising edge, where
  // every signal still holds the value it had before the edge. The reply is
  // checked before the new word is noted, since it always belongs to an
  // older word. The watchdog ends the run if no channel moves a word for
  // far longer than the slowest operation could take.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) sb.check_reply(out_if.data);
      if (in_if.valid && in_if.ready) sb.predict_reply(in_if.data);
      if (cfg_if.valid && cfg_if.ready) sb.write_register(cfg_if.data);
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_windowed_frame_buffer_writer failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It stalls in segments of random length, each with its own
  // pattern: always ready, ready at random, ready at regular intervals, or mostly ready.
  // When the stimulus arms it, it holds off for a long stretch so that the
  // command queue fills and the input channel backs up.
  // --------------------------------------------------------------------------
  initial begin
    int seg_len;
    int pattern;
    int period;
    int tick;
    out_if.ready <= 1'b0;
    tick = 0;
    forever begin
      if (hold_off_armed) begin
        hold_off_armed = 1'b0;
        repeat (LONG_HOLD) begin
          @(posedge clk);
          out_if.ready <= 1'b0;
        end
      end
      seg_len = $urandom_range(80, 10);
      pattern = $urandom_range(3);
      period  = $urandom_range(5, 2);
      repeat (seg_len) begin
        @(posedge clk);
        tick++;
        case (pattern)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(1));
          2:       out_if.ready <= (tick % period == 0);
          default: out_if.ready <= ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic in_word_t command_word(logic [2:0] op, logic [7:0] x,
                                            logic [7:0] y, logic [7:0] ce,
                                            logic [7:0] re, logic [15:0] colour,
                                            logic [13:0] addr);
    in_word_t w;
    w.operation    = op;
    w.pixel_x      = x;
    w.pixel_y      = y;
    w.col_end      = ce;
    w.row_end      = re;
    w.pixel_color  = colour;
    w.byte_address = addr;
    return w;
  endfunction

  // Offers one word and waits for it to be taken. Words go out in bursts of
  // random length; valid drops only in the gap after a burst, so a burst
  // keeps valid high from one word to the next.
  task automatic send_command(input in_word_t w);
    in_if.data  <= w;
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      if ($urandom_range(3) != 0) burst_left = $urandom_range(8, 0);
      else burst_left = $urandom_range(60, 20);
    end
  endtask

  // Waits until every word sent so far has had its reply. The first edge
  // lets the monitor note a word that was taken in the current step.
  task automatic drain_replies();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.replies_due.size() != 0);
  endtask

  // Register writes go back to back; valid is lowered once, after the last.
  task automatic put_register(input logic [1:0] index, input logic [7:0] value);
    cfg_if.data  <= '{index: index, value: value};
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic program_registers(input logic [7:0] mode_value, input logic [7:0] xl,
                                   input logic [7:0] yl, input bit poke_unused);
    put_register(CFG_DEPTH_MODE, mode_value);
    put_register(CFG_X_LIMIT, xl);
    put_register(CFG_Y_LIMIT, yl);
    if (poke_unused) put_register(CFG_UNUSED, 8'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  // Screen limits: the extremes, tiny screens where reads hit written
  // bytes often, mid-sized ones and anything at all.
  function automatic logic [7:0] pick_limit();
    case ($urandom_range(3))
      0:       return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      1:       return 8'($urandom_range(15, 1));
      2:       return 8'($urandom_range(127, 16));
      default: return 8'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence: reset, a directed part under several settings, then
  // random phases each under a fresh setting.
  // --------------------------------------------------------------------------
  initial begin
    in_word_t   w;
    logic [1:0] mode;
    logic [7:0] xl, yl;
    int         span;
    int         pick;
    int         clears_left;

    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: sixteen-bit pixels on a 96 by 64 screen. A three
    // column, two row window is written past the end of its first row so that
    // the cursor wraps from the last column to the next row. The first word
    // waits out the sweep of the store that follows reset.
    send_command(command_word(OP_SET_WINDOW, 8'd0, 8'd0, 8'd2, 8'd2, 16'h0000, 14'd0));
    send_command(command_word(OP_WRITE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF, 14'd0));
    send_command(command_word(OP_WRITE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd0));
    send_command(command_word(OP_WRITE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 16'h1234, 14'd0));
    send_command(command_word(OP_WRITE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 16'hA55A, 14'd0));
    send_command(command_word(OP_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd0));
    send_command(command_word(OP_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd193));

    // A window whose start lies beyond its end, with the start clamped to
    // the bottom right corner of the screen.
    send_command(command_word(OP_SET_WINDOW, 8'd255, 8'd255, 8'd10, 8'd0, 16'h0000, 14'd0));
    send_command(command_word(OP_WRITE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 16'h8001, 14'd0));
    send_command(command_word(OP_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd12286));

    // Draw pixel just off the screen in each direction, then on its corner.
    send_command(command_word(OP_DRAW_PIXEL, 8'd96, 8'd0, 8'd0, 8'd0, 16'hFFFF, 14'd0));
    send_command(command_word(OP_DRAW_PIXEL, 8'd0, 8'd64, 8'd0, 8'd0, 16'hFFFF, 14'd0));
    send_command(command_word(OP_DRAW_PIXEL, 8'd95, 8'd63, 8'd0, 8'd0, 16'hFFFF, 14'd0));
    send_command(command_word(OP_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd16383));

    // Clear, then read back a byte that was written before it.
    send_command(command_word(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd0));
    send_command(command_word(OP_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd12287));

    // Reserved operations with every other field at all ones.
    for (int op = OP_FIRST_RESERVED; op <= OP_LAST_RESERVED; op++) begin
      send_command(command_word(3'(op), 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 14'h3FFF));
    end

    // Eight-bit pixels on the largest screen, with junk above the format
    // bits. The far corner lies beyond the buffer; row 63 still fits.
    drain_replies();
    program_registers({6'h3F, MODE_8BIT}, 8'hFF, 8'hFF, 1'b0);
    send_command(command_word(OP_DRAW_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 16'h1111, 14'd0));
    send_command(command_word(OP_DRAW_PIXEL, 8'd0, 8'd63, 8'd0, 8'd0, 16'h00C3, 14'd0));
    send_command(command_word(OP_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd16128));

    // One-bit paged pixels: a colour with a zero low byte still sets the
    // bit, and a zero colour clears it again.
    drain_replies();
    program_registers({6'h00, MODE_1BIT}, X_LIMIT_RST, Y_LIMIT_RST, 1'b0);
    send_command(command_word(OP_DRAW_PIXEL, 8'd5, 8'd13, 8'd0, 8'd0, 16'h0100, 14'd0));
    send_command(command_word(OP_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd101));
    send_command(command_word(OP_DRAW_PIXEL, 8'd5, 8'd13, 8'd0, 8'd0, 16'h0000, 14'd0));
    send_command(command_word(OP_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd101));

    // The unused pixel format on a one by one screen stores nothing; the
    // register beyond the list is written too.
    drain_replies();
    program_registers({6'h3F, MODE_UNUSED}, 8'h00, 8'h00, 1'b1);
    send_command(command_word(OP_WRITE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF, 14'd0));
    send_command(command_word(OP_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 14'd0));

    // Random phases. The first few pin the extreme settings; the rest draw
    // a format and limits at random. Each phase starts with whatever window
    // the last one left, so limits change under a stored window.
    clears_left = MAX_RANDOM_CLEARS;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_replies();
      case (phase)
        0: begin mode = MODE_16BIT; xl = 8'hFF; yl = 8'hFF; end
        1: begin mode = MODE_1BIT;  xl = 8'h00; yl = 8'h00; end
        2: begin mode = MODE_8BIT;  xl = 8'hFF; yl = 8'h00; end
        3: begin mode = MODE_16BIT; xl = 8'h00; yl = 8'hFF; end
        default: begin
          mode = ($urandom_range(7) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
          xl   = pick_limit();
          yl   = pick_limit();
        end
      endcase
      program_registers({6'($urandom), mode}, xl, yl, $urandom_range(3) == 0);

      // Bytes that pixels on this screen can reach; most reads land there.
      case (mode)
        MODE_16BIT: span = 2 * (int'(xl) + 1) * (int'(yl) + 1);
        MODE_8BIT:  span = (int'(xl) + 1) * (int'(yl) + 1);
        default:    span = (int'(xl) + 1) * (int'(yl) / 8 + 1);
      endcase
      if (span > BUFFER_BYTES) span = BUFFER_BYTES;

      // Once, the receiver holds off while words keep coming.
      if (phase == 2) hold_off_armed = 1'b1;

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Unused fields carry random values as well.
        w = command_word(3'd0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         16'($urandom), 14'($urandom));
        case ($urandom_range(9))
          0:       w.pixel_color = 16'h0000;
          1:       w.pixel_color = 16'hFFFF;
          default: ;
        endcase
        pick = $urandom_range(99);
        if (pick < 8) begin
          w.operation = OP_SET_WINDOW;
          if ($urandom_range(9) < 7) begin
            w.pixel_x = 8'($urandom_range(xl));
            w.col_end = 8'($urandom_range(xl));
            w.pixel_y = 8'($urandom_range(yl));
            w.row_end = 8'($urandom_range(yl));
          end
        end else if (pick < 60) begin
          w.operation = OP_WRITE_PIXEL;
        end else if (pick < 72) begin
          w.operation = OP_DRAW_PIXEL;
          if ($urandom_range(4) != 0) begin
            w.pixel_x = 8'($urandom_range(xl));
            w.pixel_y = 8'($urandom_range(yl));
          end
        end else if (pick < 75) begin
          w.operation = 3'($urandom_range(OP_LAST_RESERVED, OP_FIRST_RESERVED));
        end else if (pick == 75 && clears_left > 0) begin
          w.operation = OP_CLEAR;
          clears_left--;
        end else begin
          w.operation = OP_READ_BYTE;
          if ($urandom_range(4) != 0) w.byte_address = 14'($urandom_range(span - 1));
        end
        send_command(w);
      end
    end

    // Let any stray reply show itself before the verdict.
    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("tb_windowed_frame_buffer_writer passed");
    end else begin
      $display("tb_windowed_frame_buffer_writer failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/fbw_pkg.sv
rtl/core/fbw_chan_if.sv
rtl/core/fbw_ram.sv
rtl/core/fbw_front.sv
rtl/core/fbw_cmd_fifo.sv
rtl/core/fbw_back.sv
rtl/core/windowed_frame_buffer_writer.sv
verif/tb_windowed_frame_buffer_writer.sv
